@@ rtl/clq_pkg.sv @@
`timescale 1ns / 1ps
// clq_pkg: field widths, request codes and the result bundle of the
// circular list queue manager; no dependencies

package clq_pkg;

   localparam int NODE_W  = 5;
   localparam int TYPE_W  = 3;
   localparam int COUNT_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [TYPE_W-1:0] {
      OP_PUSH_TAIL = 3'd0,
      OP_PUSH_HEAD = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_ROTATE    = 3'd3,
      OP_POP_TAIL  = 3'd4,
      OP_FIND      = 3'd5,
      OP_REMOVE    = 3'd6,
      OP_STATUS    = 3'd7
   } op_type;

   typedef struct packed {
      logic               res_valid;
      logic [NODE_W-1:0]  res_node;
      logic [NODE_W-1:0]  head;
      logic [NODE_W-1:0]  tail;
      logic               empty;
      logic [COUNT_W-1:0] count;
   } rsp_type;

endpackage

@@ rtl/clq_ram.sv @@
`timescale 1ns / 1ps
// clq_ram: next-pointer memory, one write port and one read port,
// read data registered; no dependencies

module clq_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 5,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/clq_engine.sv @@
`timescale 1ns / 1ps
// clq_engine: list sequencer holding tail, head, empty and count, and
// driving the next-pointer memory; depends on clq_pkg

module clq_engine #(
   parameter int NODES = 32,
   parameter int PTR_W = $clog2(NODES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [clq_pkg::TYPE_W-1:0] req_type,
   input  logic [clq_pkg::NODE_W-1:0] req_node,
   output logic                     done,
   input  logic                     take,
   output clq_pkg::rsp_type         rsp,
   output logic                     ram_we,
   output logic [PTR_W-1:0]         ram_waddr,
   output logic [PTR_W-1:0]         ram_wdata,
   output logic [PTR_W-1:0]         ram_raddr,
   input  logic [PTR_W-1:0]         ram_rdata
);

   import clq_pkg::*;

   localparam int STEP_W = (NODES > 2) ? $clog2(NODES) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NODES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINK,
      S_POPH,
      S_ROT,
      S_WALK,
      S_RMV,
      S_DONE
   } state_type;

   state_type          state_ff;
   op_type             op_ff;
   logic [PTR_W-1:0]   nd_ff;
   logic [PTR_W-1:0]   tail_ff;
   logic [PTR_W-1:0]   head_ff;
   logic               empty_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [PTR_W-1:0]   target_ff;
   logic [PTR_W-1:0]   pos_ff;
   logic [PTR_W-1:0]   pred_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               res_valid_ff;
   logic [PTR_W-1:0]   res_node_ff;

   op_type             req_op;
   logic [PTR_W-1:0]   req_nd;
   logic               node_ok;
   logic               hit;
   logic               walk_end;
   logic [COUNT_W-1:0] count_up;
   logic [COUNT_W-1:0] count_dn;

   assign req_op   = op_type'(req_type);
   assign req_nd   = PTR_W'(req_node);
   assign node_ok  = (32'(req_node) < NODES);
   assign hit      = (ram_rdata == target_ff);
   assign walk_end = (pos_ff == tail_ff) || (step_ff == STEP_LAST);
   assign count_up = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign count_dn = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   // memory port control
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = nd_ff;
      ram_wdata = head_ff;
      ram_raddr = head_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && node_ok &&
                (req_op == OP_PUSH_TAIL || req_op == OP_PUSH_HEAD)) begin
               ram_we    = 1'b1;
               ram_waddr = req_nd;
               ram_wdata = empty_ff ? req_nd : head_ff;
            end
         end
         S_LINK: begin
            ram_we    = 1'b1;
            ram_waddr = tail_ff;
            ram_wdata = nd_ff;
         end
         S_POPH: begin
            ram_we    = 1'b1;
            ram_waddr = tail_ff;
            ram_wdata = ram_rdata;
         end
         S_WALK: begin
            ram_raddr = ram_rdata;
            if (hit && op_ff == OP_POP_TAIL && pos_ff != tail_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = head_ff;
            end
            if (hit && op_ff == OP_REMOVE) begin
               ram_raddr = nd_ff;
            end
         end
         S_RMV: begin
            ram_we    = 1'b1;
            ram_waddr = pred_ff;
            ram_wdata = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tail_ff      <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_op;
                  nd_ff        <= req_nd;
                  res_valid_ff <= 1'b0;
                  res_node_ff  <= '0;
                  step_ff      <= '0;
                  pos_ff       <= head_ff;
                  state_ff     <= S_DONE;
                  case (req_op)
                     OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                        if (node_ok) begin
                           if (empty_ff) begin
                              tail_ff  <= req_nd;
                              head_ff  <= req_nd;
                              empty_ff <= 1'b0;
                              count_ff <= count_up;
                           end else begin
                              state_ff <= S_LINK;
                           end
                        end
                     end
                     OP_POP_HEAD, OP_REMOVE: begin
                        if (!empty_ff && (req_op == OP_POP_HEAD || node_ok)) begin
                           if (req_op == OP_POP_HEAD || head_ff == req_nd) begin
                              res_valid_ff <= 1'b1;
                              res_node_ff  <= head_ff;
                              if (head_ff == tail_ff) begin
                                 empty_ff <= 1'b1;
                                 count_ff <= count_dn;
                              end else begin
                                 state_ff <= S_POPH;
                              end
                           end else begin
                              target_ff <= req_nd;
                              state_ff  <= S_WALK;
                           end
                        end
                     end
                     OP_ROTATE: begin
                        if (!empty_ff) begin
                           state_ff <= S_ROT;
                        end
                     end
                     OP_POP_TAIL: begin
                        if (!empty_ff) begin
                           target_ff <= tail_ff;
                           state_ff  <= S_WALK;
                        end
                     end
                     OP_FIND: begin
                        if (!empty_ff && node_ok) begin
                           target_ff <= req_nd;
                           state_ff  <= S_WALK;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_LINK: begin
               count_ff <= count_up;
               if (op_ff == OP_PUSH_TAIL) begin
                  tail_ff <= nd_ff;
               end
               // a head push makes the node the head; so does the tail pushed
               // onto itself, which leaves it linked to itself
               if (op_ff == OP_PUSH_HEAD || nd_ff == tail_ff) begin
                  head_ff <= nd_ff;
               end
               state_ff <= S_DONE;
            end
            S_POPH: begin
               head_ff  <= ram_rdata;
               count_ff <= count_dn;
               state_ff <= S_DONE;
            end
            S_ROT: begin
               tail_ff  <= head_ff;
               head_ff  <= ram_rdata;
               state_ff <= S_DONE;
            end
            S_WALK: begin
               if (hit) begin
                  pred_ff <= pos_ff;
                  case (op_ff)
                     OP_FIND: begin
                        res_valid_ff <= 1'b1;
                        res_node_ff  <= nd_ff;
                        state_ff     <= S_DONE;
                     end
                     OP_POP_TAIL: begin
                        res_valid_ff <= 1'b1;
                        res_node_ff  <= tail_ff;
                        count_ff     <= count_dn;
                        if (pos_ff == tail_ff) begin
                           empty_ff <= 1'b1;
                        end else begin
                           tail_ff <= pos_ff;
                        end
                        state_ff <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_RMV;
                     end
                  endcase
               end else if (walk_end) begin
                  state_ff <= S_DONE;
               end else begin
                  pos_ff  <= ram_rdata;
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_RMV: begin
               res_valid_ff <= 1'b1;
               res_node_ff  <= nd_ff;
               count_ff     <= count_dn;
               if (nd_ff == tail_ff) begin
                  tail_ff <= pred_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign done          = (state_ff == S_DONE);
   assign rsp.res_valid = res_valid_ff;
   assign rsp.res_node  = res_valid_ff ? NODE_W'(res_node_ff) : '0;
   assign rsp.head      = empty_ff ? '0 : NODE_W'(head_ff);
   assign rsp.tail      = empty_ff ? '0 : NODE_W'(tail_ff);
   assign rsp.empty     = empty_ff;
   assign rsp.count     = count_ff;

endmodule

@@ rtl/circular_list_queue_manager.sv @@
`timescale 1ns / 1ps
// circular_list_queue_manager: top level, output register around the
// sequencer and next-pointer memory; depends on clq_pkg, clq_engine, clq_ram
//
// One circular singly linked list over NODES node indices. The list lives in
// a next-pointer memory (one write port, one registered read port) plus a
// tail register; the head is kept as a copy of the tail's successor. One
// request is worked at a time. Status, requests that change nothing, a push
// onto an empty list and a pop head or remove of the only node finish from
// the idle state; other pushes pass through a link state, pop head and
// remove of the head node through a pop state, and rotate through a rotate
// state. Pop tail and find walk from the head over 1 to NODES nodes to the
// predecessor, and remove of any other node walks and then unlinks in a
// remove state; the walk does one memory read a cycle.
// A finished result sits in the output register while the next request is
// taken. The memory needs no clearing after reset: a node's entry is written
// when it is pushed, before it is ever read.

module circular_list_queue_manager #(
   parameter int NODES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [clq_pkg::TYPE_W-1:0]      req_type,
   input  logic [clq_pkg::NODE_W-1:0]      req_node,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [clq_pkg::NODE_W-1:0]      rsp_result_node,
   output logic                            rsp_result_valid,
   output logic [clq_pkg::NODE_W-1:0]      rsp_head_node,
   output logic [clq_pkg::NODE_W-1:0]      rsp_tail_node,
   output logic                            rsp_is_empty,
   output logic [clq_pkg::COUNT_W-1:0]     rsp_node_count
);

   import clq_pkg::*;

   localparam int PTR_W = $clog2(NODES);

   // sequencer to memory
   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [PTR_W-1:0] ram_wdata;
   logic [PTR_W-1:0] ram_raddr;
   logic [PTR_W-1:0] ram_rdata;

   // finished result from the sequencer
   logic             eng_done;
   logic             eng_take;
   rsp_type          eng_rsp;

   // output register
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   clq_engine #(
      .NODES (NODES),
      .PTR_W (PTR_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_node  (req_node),
      .done      (eng_done),
      .take      (eng_take),
      .rsp       (eng_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   clq_ram #(
      .DEPTH  (NODES),
      .WIDTH  (PTR_W),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // load when the register is empty or its transfer completes this cycle
   assign eng_take = eng_done && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload holds while stalled, since eng_take is low then
   always_ff @(posedge clock) begin
      if (eng_take) begin
         rsp_ff <= eng_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_node  = rsp_ff.res_node;
   assign rsp_result_valid = rsp_ff.res_valid;
   assign rsp_head_node    = rsp_ff.head;
   assign rsp_tail_node    = rsp_ff.tail;
   assign rsp_is_empty     = rsp_ff.empty;
   assign rsp_node_count   = rsp_ff.count;

endmodule

@@ verif/clq_tb_pkg.sv @@
`timescale 1ns / 1ps
// clq_tb_pkg: list scoreboard for the circular list queue manager bench,
// predicts every list view and checks the block's results; depends on clq_pkg

package clq_tb_pkg;

   import clq_pkg::*;

   localparam int LIST_NODES = 32;

   class list_scoreboard;

      logic [NODE_W-1:0]  tail_q;
      bit                 empty_q;
      logic [NODE_W-1:0]  link_q [LIST_NODES];
      logic [COUNT_W-1:0] count_q;
      rsp_type            list_views_q [$];
      int                 errors;

      function new();
         tail_q  = '0;
         empty_q = 1'b1;
         count_q = '0;
         errors  = 0;
         foreach (link_q[k]) link_q[k] = '0;
      endfunction

      function int views_pending();
         return list_views_q.size();
      endfunction

      function bit is_empty();
         return empty_q;
      endfunction

      function logic [NODE_W-1:0] tail_node();
         return tail_q;
      endfunction

      // membership by a bounded walk from the head
      function bit is_linked(logic [NODE_W-1:0] n);
         logic [NODE_W-1:0] pos;
         if (empty_q) return 1'b0;
         pos = tail_q;
         for (int k = 0; k < LIST_NODES; k++) begin
            pos = link_q[pos];
            if (pos == n) return 1'b1;
            if (pos == tail_q) return 1'b0;
         end
         return 1'b0;
      endfunction

      function void count_up();
         if (count_q < COUNT_MAX) count_q = count_q + 1'b1;
      endfunction

      function void count_down();
         if (count_q != '0) count_q = count_q - 1'b1;
      endfunction

      // walk from the head looking for the node whose successor is target
      function bit locate_pred(logic [NODE_W-1:0] target, output logic [NODE_W-1:0] pred);
         logic [NODE_W-1:0] pos;
         pos  = tail_q;
         pred = '0;
         for (int k = 0; k < LIST_NODES; k++) begin
            pos = link_q[pos];
            if (link_q[pos] == target) begin
               pred = pos;
               return 1'b1;
            end
            if (pos == tail_q) break;
         end
         return 1'b0;
      endfunction

      function logic [NODE_W-1:0] unlink_head();
         logic [NODE_W-1:0] first;
         first = link_q[tail_q];
         if (first == tail_q) empty_q = 1'b1;
         else link_q[tail_q] = link_q[first];
         count_down();
         return first;
      endfunction

      // apply one accepted request and queue the list view it produces
      function void note_request(op_type op, logic [NODE_W-1:0] nd);
         rsp_type           view;
         logic [NODE_W-1:0] pred;
         logic [NODE_W-1:0] res;
         bit                hit;
         hit = 1'b0;
         res = '0;
         case (op)
            OP_PUSH_TAIL, OP_PUSH_HEAD: begin
               if (!empty_q) begin
                  link_q[nd]     = link_q[tail_q];
                  link_q[tail_q] = nd;
                  if (op == OP_PUSH_TAIL) tail_q = nd;
               end else begin
                  link_q[nd] = nd;
                  tail_q     = nd;
                  empty_q    = 1'b0;
               end
               count_up();
            end
            OP_POP_HEAD: begin
               if (!empty_q) begin
                  res = unlink_head();
                  hit = 1'b1;
               end
            end
            OP_ROTATE: begin
               if (!empty_q) tail_q = link_q[tail_q];
            end
            OP_POP_TAIL: begin
               if (!empty_q && locate_pred(tail_q, pred)) begin
                  res = tail_q;
                  hit = 1'b1;
                  if (pred == tail_q) begin
                     empty_q = 1'b1;
                  end else begin
                     link_q[pred] = link_q[tail_q];
                     tail_q       = pred;
                  end
                  count_down();
               end
            end
            OP_FIND: begin
               if (!empty_q && locate_pred(nd, pred)) begin
                  res = nd;
                  hit = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (!empty_q) begin
                  if (link_q[tail_q] == nd) begin
                     res = unlink_head();
                     hit = 1'b1;
                  end else if (locate_pred(nd, pred)) begin
                     link_q[pred] = link_q[nd];
                     if (nd == tail_q) tail_q = pred;
                     count_down();
                     res = nd;
                     hit = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         view.res_valid = hit;
         view.res_node  = hit ? res : '0;
         view.head      = empty_q ? '0 : link_q[tail_q];
         view.tail      = empty_q ? '0 : tail_q;
         view.empty     = empty_q;
         view.count     = count_q;
         list_views_q.push_back(view);
      endfunction

      function void log_mismatch(string what, rsp_type want, rsp_type got);
         if (errors < 10) begin
            $write("%s: want res %0b/%0d head %0d tail %0d empty %0b count %0d, ",
                   what, want.res_valid, want.res_node, want.head, want.tail,
                   want.empty, want.count);
            $display("got res %0b/%0d head %0d tail %0d empty %0b count %0d",
                     got.res_valid, got.res_node, got.head, got.tail, got.empty,
                     got.count);
         end
         errors++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         bit      bad;
         if (list_views_q.size() == 0) begin
            log_mismatch("result with nothing pending", '0, got);
            return;
         end
         want = list_views_q.pop_front();
         bad  = (got.res_valid != want.res_valid) || (got.res_node != want.res_node) ||
                (got.head != want.head) || (got.tail != want.tail) ||
                (got.empty != want.empty) || (got.count != want.count);
         if (bad) log_mismatch("result mismatch", want, got);
      endfunction

   endclass

endpackage

@@ verif/circular_list_queue_manager_tb.sv @@
`timescale 1ns / 1ps
// circular_list_queue_manager_tb: directed and random list operations with
// random idling and stalls on both channels; depends on clq_pkg, clq_tb_pkg

module circular_list_queue_manager_tb;

   import clq_pkg::*;
   import clq_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1475;
   localparam int DUP_ITEMS    = 130;   // closing stretch with re-pushed nodes
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TYPE_W-1:0]   req_type = OP_STATUS;
   logic [NODE_W-1:0]   req_node = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [NODE_W-1:0]   rsp_result_node;
   logic                rsp_result_valid;
   logic [NODE_W-1:0]   rsp_head_node;
   logic [NODE_W-1:0]   rsp_tail_node;
   logic                rsp_is_empty;
   logic [COUNT_W-1:0]  rsp_node_count;

   list_scoreboard sb = new();

   // idling controls shared between the sender and the receiver
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit hold_req  = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;

   circular_list_queue_manager #(.NODES(LIST_NODES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_node  (rsp_result_node),
      .rsp_result_valid (rsp_result_valid),
      .rsp_head_node    (rsp_head_node),
      .rsp_tail_node    (rsp_tail_node),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_node_count   (rsp_node_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_list_queue_manager_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, a quiet stretch, and one long hold-off
   // counted here so the block backs up into its input
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rx_steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 33);
      end
   end

   // result transfers are checked against the oldest predicted view
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_result_valid, rsp_result_node, rsp_head_node,
                            rsp_tail_node, rsp_is_empty, rsp_node_count});
   end

   // offer one request, with random idle cycles ahead of it; returns at the
   // edge of the transfer, after the prediction has been updated
   task automatic send_item(input op_type op, input logic [NODE_W-1:0] nd);
      while (!tx_steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_node  <= nd;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(op, nd);
   endtask

   // random node that is (or is not) in the list; falls back to any node
   function automatic logic [NODE_W-1:0] pick_node(bit member);
      logic [NODE_W-1:0] n;
      n = NODE_W'($urandom_range(LIST_NODES - 1));
      for (int k = 0; k < LIST_NODES; k++) begin
         if (sb.is_linked(n) == member) return n;
         n = n + 1'b1;
      end
      return n;
   endfunction

   initial begin : main_seq
      op_type            op;
      logic [NODE_W-1:0] nd;
      mix_type           mix;
      int                r;
      int                push_w;

      mix = MIX_EVEN;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list: every operation reports nothing
      send_item(OP_STATUS,    5'd0);
      send_item(OP_POP_HEAD,  5'd0);
      send_item(OP_POP_TAIL,  5'd0);
      send_item(OP_ROTATE,    5'd0);
      send_item(OP_FIND,      5'd0);
      send_item(OP_REMOVE,    5'd31);
      // single node list
      send_item(OP_PUSH_TAIL, 5'd0);
      send_item(OP_FIND,      5'd0);
      send_item(OP_ROTATE,    5'd0);
      send_item(OP_POP_TAIL,  5'd0);
      send_item(OP_PUSH_HEAD, 5'd31);
      send_item(OP_REMOVE,    5'd31);
      // list of four: 31 5 10 0
      send_item(OP_PUSH_TAIL, 5'd5);
      send_item(OP_PUSH_TAIL, 5'd10);
      send_item(OP_PUSH_HEAD, 5'd31);
      send_item(OP_PUSH_TAIL, 5'd0);
      send_item(OP_FIND,      5'd10);
      // node not in the list
      send_item(OP_FIND,      5'd7);
      send_item(OP_REMOVE,    5'd7);
      send_item(OP_ROTATE,    5'd0);
      // remove a middle node, then the tail
      send_item(OP_REMOVE,    5'd10);
      send_item(OP_REMOVE,    5'd31);
      send_item(OP_POP_TAIL,  5'd0);
      send_item(OP_POP_HEAD,  5'd0);
      send_item(OP_STATUS,    5'd31);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 60 == 0) mix = mix_type'($urandom_range(2));
         // long receiver hold-off while requests keep coming
         if (i == 300) hold_req = 1'b1;
         // sender pause until every result is back
         if (i == 700) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.views_pending() != 0);
         end
         tx_steady = (i >= 900 && i < 1100);
         rx_steady = (i >= 900 && i < 1100);

         if (i >= RANDOM_ITEMS - DUP_ITEMS) begin
            if (i < RANDOM_ITEMS - DUP_ITEMS + 70) begin
               // re-push the tail over and over: count runs up to saturation
               op = OP_PUSH_TAIL;
               nd = sb.is_empty() ? pick_node(1'b0) : sb.tail_node();
            end else begin
               // anything goes, nodes already linked included
               op = op_type'($urandom_range(7));
               nd = NODE_W'($urandom_range(LIST_NODES - 1));
            end
         end else if ($urandom_range(99) < 10) begin
            // noise: any operation on any node, still no double push
            op = op_type'($urandom_range(7));
            nd = NODE_W'($urandom_range(LIST_NODES - 1));
            if ((op == OP_PUSH_TAIL || op == OP_PUSH_HEAD) && sb.is_linked(nd)) begin
               nd = pick_node(1'b0);
               if (sb.is_linked(nd)) op = OP_STATUS;
            end
         end else begin
            // well-formed traffic, weighted to fill or drain the pool
            push_w = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 20 : 40;
            r = $urandom_range(99);
            if (r < push_w) begin
               op = $urandom_range(1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
               nd = pick_node(1'b0);
               if (sb.is_linked(nd)) op = OP_FIND;   // pool is full
            end else begin
               op = op_type'($urandom_range(7, 2));
               nd = pick_node($urandom_range(3) != 0);
            end
         end
         send_item(op, nd);
      end

      tx_steady = 1'b0;
      rx_steady = 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.views_pending() != 0);
      // stray results would show up here
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("circular_list_queue_manager_tb: done, clean");
      else
         $display("circular_list_queue_manager_tb: done, errors");
      $finish;
   end

endmodule

@@ circular_list_queue_manager.f @@
rtl/clq_pkg.sv
rtl/clq_ram.sv
rtl/clq_engine.sv
rtl/circular_list_queue_manager.sv
verif/clq_tb_pkg.sv
verif/circular_list_queue_manager_tb.sv
